@@ src/lfu_cache_lru_tiebreak_core_assert.svh @@
// Assertion macros used by the LFU cache controller.
`ifndef LFU_CACHE_LRU_TIEBREAK_CORE_ASSERT_SVH
`define LFU_CACHE_LRU_TIEBREAK_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Property checked on every rising clk_i edge, disabled while rst_ni is low.
`define LFULRU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never hold at a rising clk_i edge.
`define LFULRU_ASSERT_NEVER(lbl, cond, msg) \
  `LFULRU_ASSERT(lbl, !(cond), msg)

`else

`define LFULRU_ASSERT(lbl, prop, msg)

`define LFULRU_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

@@ src/lfulru_pkg.sv @@
// Shared constants and types of the LFU cache with LRU tie break.
package lfulru_pkg;

  localparam int unsigned MAX_ENTRIES = 16;
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned CAP_W       = 5;

  localparam int unsigned IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned RANK_W = IDX_W;
  localparam int unsigned OCC_W  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMP_W  = (CAP_W > OCC_W) ? CAP_W : OCC_W;

  localparam logic [CAP_W-1:0]   CAP_RESET = CAP_W'(16);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(MAX_ENTRIES - 1);

  // Request type codes.
  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } ctrl_state_e;

  typedef struct packed {
    logic load;    // capture the request and restart the scan
    logic scan;    // examine one entry
    logic commit;  // update the entries and load the result register
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;
  } dp_status_t;

endpackage

@@ src/lfulru_ctrl.sv @@
// Controller: sequences accept, entry scan and commit, and owns the result valid.
`include "lfu_cache_lru_tiebreak_core_assert.svh"

module lfulru_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output lfulru_pkg::dp_cmd_t   cmd_o,
  input  lfulru_pkg::dp_status_t status_i
);

  lfulru_pkg::ctrl_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lfulru_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      lfulru_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = lfulru_pkg::ST_SCAN;
        end
      end
      lfulru_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_last) begin
          state_d = lfulru_pkg::ST_COMMIT;
        end
      end
      lfulru_pkg::ST_COMMIT: begin
        // The entries are updated only once the result register can take the answer.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = lfulru_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lfulru_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  `LFULRU_ASSERT(a_commit_free, cmd_o.commit |-> (!out_valid_q || out_ready_i), "commit over a pending result")
  `LFULRU_ASSERT(a_load_scan, cmd_o.load |=> (state_q == lfulru_pkg::ST_SCAN), "load did not start scan")
  `LFULRU_ASSERT(a_scan_end, cmd_o.scan && status_i.scan_last |=> (state_q == lfulru_pkg::ST_COMMIT), "scan end missed")
  `LFULRU_ASSERT(a_valid_src, $rose(out_valid_q) |-> $past(cmd_o.commit), "result valid without commit")
  `LFULRU_ASSERT_NEVER(a_busy_ready, in_ready_o && (cmd_o.scan || cmd_o.commit), "ready while busy")

endmodule

@@ src/lfulru_dp.sv @@
// Datapath: entry storage, sequential scan for key, free slot and victim, and the update.
module lfulru_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lfulru_pkg::dp_cmd_t              cmd_i,
  output lfulru_pkg::dp_status_t           status_o,
  input  logic [lfulru_pkg::CAP_W-1:0]     capacity_i,
  input  logic                             req_type_i,
  input  logic [lfulru_pkg::KEY_W-1:0]     req_key_i,
  input  logic [lfulru_pkg::VAL_W-1:0]     req_value_i,
  output logic                             hit_o,
  output logic [lfulru_pkg::VAL_W-1:0]     read_value_o,
  output logic                             evicted_o
);

  localparam int unsigned N = lfulru_pkg::MAX_ENTRIES;

  // Entry storage.
  logic [N-1:0]                       valid_q, valid_d;
  logic [lfulru_pkg::RANK_W-1:0]      rank_q [N];
  logic [lfulru_pkg::RANK_W-1:0]      rank_d [N];
  logic [lfulru_pkg::KEY_W-1:0]       key_mem [N];
  logic [lfulru_pkg::VAL_W-1:0]       val_mem [N];
  logic [lfulru_pkg::COUNT_W-1:0]     cnt_mem [N];
  logic [lfulru_pkg::OCC_W-1:0]       occ_q, occ_d;

  // Captured request and scan position.
  logic                               req_type_q;
  logic [lfulru_pkg::KEY_W-1:0]       req_key_q;
  logic [lfulru_pkg::VAL_W-1:0]       req_val_q;
  logic [lfulru_pkg::IDX_W-1:0]       idx_q;

  // Scan results.
  logic                               found_q, free_found_q, vic_found_q;
  logic [lfulru_pkg::IDX_W-1:0]       found_idx_q, free_idx_q, vic_idx_q;
  logic [lfulru_pkg::VAL_W-1:0]       found_val_q;
  logic [lfulru_pkg::COUNT_W-1:0]     found_cnt_q, vic_cnt_q;
  logic [lfulru_pkg::RANK_W-1:0]      found_rank_q, vic_rank_q;

  // Result register.
  logic                               hit_q, evict_q;
  logic [lfulru_pkg::VAL_W-1:0]       rdata_q;

  // Entry under the scan pointer.
  logic                               cur_valid;
  logic [lfulru_pkg::KEY_W-1:0]       cur_key;
  logic [lfulru_pkg::VAL_W-1:0]       cur_val;
  logic [lfulru_pkg::COUNT_W-1:0]     cur_cnt;
  logic [lfulru_pkg::RANK_W-1:0]      cur_rank;
  logic                               take_match, take_free, take_vic;

  assign cur_valid = valid_q[idx_q];
  assign cur_key   = key_mem[idx_q];
  assign cur_val   = val_mem[idx_q];
  assign cur_cnt   = cnt_mem[idx_q];
  assign cur_rank  = rank_q[idx_q];

  assign take_match = cur_valid && (cur_key == req_key_q) && !found_q;
  assign take_free  = !cur_valid && !free_found_q;
  // Lowest count wins; on equal counts the older entry (higher rank) wins.
  assign take_vic   = cur_valid && (!vic_found_q || (cur_cnt < vic_cnt_q) ||
                      ((cur_cnt == vic_cnt_q) && (cur_rank > vic_rank_q)));

  assign status_o.scan_last = (idx_q == lfulru_pkg::LAST_IDX);

  // Commit decisions.
  logic [lfulru_pkg::CMP_W-1:0]       cap_w, cap_eff;
  logic                               use_free, do_insert, do_evict, age_en, age_all;
  logic [lfulru_pkg::IDX_W-1:0]       tgt;
  logic [lfulru_pkg::RANK_W-1:0]      ref_rank;
  logic                               wr_key, wr_val, wr_cnt;
  logic [lfulru_pkg::VAL_W-1:0]       wr_val_data;
  logic [lfulru_pkg::COUNT_W-1:0]     wr_cnt_data;

  always_comb begin
    cap_w    = lfulru_pkg::CMP_W'(capacity_i);
    cap_eff  = (cap_w > lfulru_pkg::CMP_W'(N)) ? lfulru_pkg::CMP_W'(N) : cap_w;
    use_free = (lfulru_pkg::CMP_W'(occ_q) < cap_eff) && free_found_q;
    do_insert = !found_q && (req_type_q == lfulru_pkg::REQ_PUT) &&
                (cap_eff != '0) && (use_free || vic_found_q);
    do_evict = do_insert && !use_free;
    tgt      = found_q ? found_idx_q : (use_free ? free_idx_q : vic_idx_q);
    ref_rank = found_q ? found_rank_q : vic_rank_q;
    age_en   = found_q || do_insert;
    age_all  = !found_q && use_free;

    wr_key      = do_insert;
    wr_val      = do_insert || (found_q && (req_type_q == lfulru_pkg::REQ_PUT));
    wr_cnt      = age_en;
    wr_val_data = req_val_q;
    if (found_q) begin
      wr_cnt_data = (found_cnt_q == lfulru_pkg::COUNT_MAX) ? found_cnt_q : found_cnt_q + 1'b1;
    end else begin
      wr_cnt_data = lfulru_pkg::COUNT_W'(1);
    end

    valid_d = valid_q;
    occ_d   = occ_q;
    for (int i = 0; i < N; i++) begin
      rank_d[i] = rank_q[i];
      if (age_en && valid_q[i] && (tgt != lfulru_pkg::IDX_W'(i)) &&
          (age_all || (rank_q[i] < ref_rank))) begin
        rank_d[i] = rank_q[i] + 1'b1;
      end
    end
    if (age_en) begin
      rank_d[tgt] = '0;
    end
    if (do_insert) begin
      valid_d[tgt] = 1'b1;
    end
    // An eviction frees one slot and the insert fills it again.
    if (do_insert && use_free) begin
      occ_d = occ_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      occ_q        <= '0;
      idx_q        <= '0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      vic_found_q  <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        idx_q        <= '0;
        found_q      <= 1'b0;
        free_found_q <= 1'b0;
        vic_found_q  <= 1'b0;
      end else if (cmd_i.scan) begin
        idx_q <= idx_q + 1'b1;
        if (take_match) begin
          found_q <= 1'b1;
        end
        if (take_free) begin
          free_found_q <= 1'b1;
        end
        if (take_vic) begin
          vic_found_q <= 1'b1;
        end
      end
      if (cmd_i.commit) begin
        valid_q <= valid_d;
        occ_q   <= occ_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_type_q <= req_type_i;
      req_key_q  <= req_key_i;
      req_val_q  <= req_value_i;
    end
    if (cmd_i.scan) begin
      if (take_match) begin
        found_idx_q  <= idx_q;
        found_val_q  <= cur_val;
        found_cnt_q  <= cur_cnt;
        found_rank_q <= cur_rank;
      end
      if (take_free) begin
        free_idx_q <= idx_q;
      end
      if (take_vic) begin
        vic_idx_q  <= idx_q;
        vic_cnt_q  <= cur_cnt;
        vic_rank_q <= cur_rank;
      end
    end
    if (cmd_i.commit) begin
      rank_q <= rank_d;
      if (wr_key) begin
        key_mem[tgt] <= req_key_q;
      end
      if (wr_val) begin
        val_mem[tgt] <= wr_val_data;
      end
      if (wr_cnt) begin
        cnt_mem[tgt] <= wr_cnt_data;
      end
      hit_q   <= found_q;
      evict_q <= do_evict;
      rdata_q <= (found_q && (req_type_q == lfulru_pkg::REQ_GET)) ? found_val_q : '0;
    end
  end

  assign hit_o        = hit_q;
  assign read_value_o = rdata_q;
  assign evicted_o    = evict_q;

endmodule

@@ src/lfu_cache_lru_tiebreak_core.sv @@
// Top level of the LFU key-value cache with LRU tie break.
//
// Requests arrive on in_valid_i/in_ready_o with req_type_i (0 get, 1 put),
// req_key_i and req_value_i. Each request yields one result on
// out_valid_o/out_ready_i: hit_o, read_value_o (value on a get hit, else zero)
// and evicted_o (a put that removed an entry to make room).
// A request is taken only while the block is idle. It then scans the entries
// one per cycle, looking for the key, the first free slot and the eviction
// victim, then updates the entries and loads the result register; the next
// request is not taken until that update is done.
// The result sits in an output register, so the next request is accepted and
// scanned while a result still waits; if the receiver stalls, the update step
// holds until the waiting result is taken.
// Reset empties the cache and sets the capacity register to 16. The capacity
// is written through cfg_we_i/cfg_wdata_i; the user must write it only while
// no request is in flight, as the block itself does not enforce this.
module lfu_cache_lru_tiebreak_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lfulru_pkg::CAP_W-1:0]     cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             req_type_i,
  input  logic [lfulru_pkg::KEY_W-1:0]     req_key_i,
  input  logic [lfulru_pkg::VAL_W-1:0]     req_value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             hit_o,
  output logic [lfulru_pkg::VAL_W-1:0]     read_value_o,
  output logic                             evicted_o
);

  logic [lfulru_pkg::CAP_W-1:0] capacity_q;
  lfulru_pkg::dp_cmd_t          cmd;
  lfulru_pkg::dp_status_t       status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= lfulru_pkg::CAP_RESET;
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
    end
  end

  lfulru_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  lfulru_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .capacity_i   (capacity_q),
    .req_type_i   (req_type_i),
    .req_key_i    (req_key_i),
    .req_value_i  (req_value_i),
    .hit_o        (hit_o),
    .read_value_o (read_value_o),
    .evicted_o    (evicted_o)
  );

endmodule
